FILE: sv/spsi_pkg.sv
// Shared constants, types and codes for the sorted pair set insert unit.
package spsi_pkg;

  // Set size and key width
  localparam int CAPACITY     = 256;
  localparam int KEY_BITS     = 16;

  // Port widths of the request and result fields
  localparam int IN_KEY_W     = 16;
  localparam int OUT_STATUS_W = 2;
  localparam int OUT_NUM_W    = 9;

  // Derived widths
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int GRP_SIZE     = 16;
  localparam int GRP_W        = $clog2(GRP_SIZE);
  localparam int NGRP         = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NGRP_W       = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD          = NGRP * GRP_SIZE;
  localparam int POS_W        = NGRP_W + GRP_W;

  typedef logic [IN_KEY_W-1:0]  in_key_t;
  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [GRP_W-1:0]     grp_idx_t;
  typedef logic [NGRP_W-1:0]    grp_num_t;
  typedef logic [PAD-1:0]       pad_vec_t;
  typedef logic [CAPACITY-1:0]  cell_vec_t;
  typedef logic [OUT_NUM_W-1:0] out_num_t;

  // One stored key pair, compared first key then second key
  typedef struct packed {
    key_t first;
    key_t second;
  } pair_t;

  // Result status codes
  typedef enum logic [OUT_STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctl_t;

endpackage

FILE: sv/spsi_cell.sv
// One cell of the sorted row: holds a pair, compares it, shifts from its left neighbor.
module spsi_cell (
  input  logic               clk,
  input  spsi_pkg::cell_ctl_t ctl,
  input  spsi_pkg::pair_t    new_pair,
  input  logic               valid,
  input  spsi_pkg::pair_t    left_pair,
  input  logic               left_ge,
  output spsi_pkg::pair_t    pair,
  output logic               ge,
  output logic               ins,
  output logic               eq
);

  spsi_pkg::pair_t pair_r;
  logic            ge_r;
  logic            eq_r;
  logic            gt;
  logic            same;

  // Compare the stored pair against the new one
  always_comb begin
    gt   = (new_pair.first < pair_r.first) ||
           ((new_pair.first == pair_r.first) && (new_pair.second < pair_r.second));
    same = (new_pair == pair_r);
  end

  // Latch flags: an empty cell counts as above the insert point
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      ge_r <= !valid || gt;
      eq_r <= valid && same;
    end
  end

  // Shift up from the left, or take the new pair at the insert point
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      if (ins) begin
        pair_r <= new_pair;
      end else if (ge_r && left_ge) begin
        pair_r <= left_pair;
      end
    end
  end

  assign pair = pair_r;
  assign ge   = ge_r;
  assign ins  = ge_r && !left_ge;
  assign eq   = eq_r;

endmodule

FILE: sv/spsi_enc.sv
// Two-level registered encoder: insert point and duplicate flag from the cell flags.
module spsi_enc (
  input  logic                  clk,
  input  logic                  latch_en,
  input  spsi_pkg::cell_vec_t   ins_vec,
  input  spsi_pkg::cell_vec_t   eq_vec,
  output logic                  dup,
  output spsi_pkg::pos_t        pos
);

  logic [spsi_pkg::NGRP-1:0] grp_hit_r;
  logic [spsi_pkg::NGRP-1:0] grp_eq_r;
  spsi_pkg::grp_idx_t        grp_idx_r [spsi_pkg::NGRP];
  logic [spsi_pkg::NGRP-1:0] grp_hit_nxt;
  logic [spsi_pkg::NGRP-1:0] grp_eq_nxt;
  spsi_pkg::grp_idx_t        grp_idx_nxt [spsi_pkg::NGRP];
  spsi_pkg::pad_vec_t        ins_pad;
  spsi_pkg::pad_vec_t        eq_pad;
  spsi_pkg::pos_t            ins_pos;

  assign ins_pad = spsi_pkg::pad_vec_t'(ins_vec);
  assign eq_pad  = spsi_pkg::pad_vec_t'(eq_vec);

  // Encode each group of cells on its own
  always_comb begin
    for (int g = 0; g < spsi_pkg::NGRP; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_eq_nxt[g]  = 1'b0;
      grp_idx_nxt[g] = '0;
      for (int j = 0; j < spsi_pkg::GRP_SIZE; j++) begin
        if (ins_pad[g*spsi_pkg::GRP_SIZE + j]) begin
          grp_hit_nxt[g] = 1'b1;
          grp_idx_nxt[g] = grp_idx_nxt[g] | spsi_pkg::grp_idx_t'(j);
        end
        if (eq_pad[g*spsi_pkg::GRP_SIZE + j]) begin
          grp_eq_nxt[g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch_en) begin
      grp_hit_r <= grp_hit_nxt;
      grp_eq_r  <= grp_eq_nxt;
      grp_idx_r <= grp_idx_nxt;
    end
  end

  // Combine the groups; a duplicate sits just below the insert point
  always_comb begin
    ins_pos = '0;
    for (int g = 0; g < spsi_pkg::NGRP; g++) begin
      if (grp_hit_r[g]) begin
        ins_pos = ins_pos | {spsi_pkg::grp_num_t'(g), grp_idx_r[g]};
      end
    end
  end

  assign dup = |grp_eq_r;
  assign pos = dup ? (ins_pos - spsi_pkg::pos_t'(1)) : ins_pos;

endmodule

FILE: sv/sorted_pair_set_insert_unit.sv
// Sorted pair set insert unit: top level with the cell row, encoder and control.
//
// Keeps up to CAPACITY distinct (first, second) key pairs in ascending order in a row of
// cells. Each request passes through four steps from acceptance to a valid result: all
// cells compare against the latched pair, the registered insert point encoder latches,
// the row shifts and writes the pair, and the result moves into the output register.
// The unit takes a new request only in idle, after the previous one has gone through
// the compare, encode, shift and result sequence over the row. A request
// may be accepted while the previous result still waits at the output; the one after it
// waits until that result is taken. Overflow is reported when the set is full, ahead of
// the duplicate check; a duplicate leaves the set unchanged and reports where the equal
// pair sits.
module sorted_pair_set_insert_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spsi_pkg::in_key_t     in_first_key,
  input  spsi_pkg::in_key_t     in_second_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output spsi_pkg::out_num_t    out_position,
  output spsi_pkg::out_num_t    out_count
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_ENC  = 5'b00100,
    S_UPD  = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  spsi_pkg::pair_t     new_r;
  spsi_pkg::cnt_t      count_r;
  spsi_pkg::status_t   res_status_r;
  spsi_pkg::pos_t      res_pos_r;
  logic                out_valid_r;
  spsi_pkg::status_t   out_status_r;
  spsi_pkg::out_num_t  out_position_r;
  spsi_pkg::out_num_t  out_count_r;

  spsi_pkg::cell_ctl_t ctl;
  spsi_pkg::pair_t     cell_pair [spsi_pkg::CAPACITY];
  spsi_pkg::cell_vec_t cell_ge;
  spsi_pkg::cell_vec_t cell_ins;
  spsi_pkg::cell_vec_t cell_eq;
  logic                dup;
  spsi_pkg::pos_t      pos;
  logic                full;
  logic                in_take;
  logic                out_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign full     = (count_r == spsi_pkg::cnt_t'(spsi_pkg::CAPACITY));
  assign out_load = (state_r == S_RES) && (!out_valid_r || out_ready);

  // Drive the row: compare in the compare state, shift in the update state unless full or duplicate
  always_comb begin
    ctl.cmp_en   = (state_r == S_CMP);
    ctl.shift_en = (state_r == S_UPD) && !full && !dup;
  end

  // Build the row of cells, each fed by its left neighbor
  for (genvar i = 0; i < spsi_pkg::CAPACITY; i++) begin : g_cell
    spsi_pkg::pair_t left_pair;
    logic            left_ge;
    if (i == 0) begin : g_first
      assign left_pair = new_r;
      assign left_ge   = 1'b0;
    end else begin : g_rest
      assign left_pair = cell_pair[i-1];
      assign left_ge   = cell_ge[i-1];
    end
    spsi_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_pair  (new_r),
      .valid     (count_r > spsi_pkg::cnt_t'(i)),
      .left_pair (left_pair),
      .left_ge   (left_ge),
      .pair      (cell_pair[i]),
      .ge        (cell_ge[i]),
      .ins       (cell_ins[i]),
      .eq        (cell_eq[i])
    );
  end

  spsi_enc u_enc (
    .clk      (clk),
    .latch_en (state_r == S_ENC),
    .ins_vec  (cell_ins),
    .eq_vec   (cell_eq),
    .dup      (dup),
    .pos      (pos)
  );

  // Sequence one request through compare, encode, update and result
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_take) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_ENC;
      S_ENC:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_RES;
      S_RES:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the request keys, trimmed to the key width
  always_ff @(posedge clk) begin
    if (in_take) begin
      new_r.first  <= spsi_pkg::key_t'(in_first_key);
      new_r.second <= spsi_pkg::key_t'(in_second_key);
    end
  end

  // Advance the entry count on an insert
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.shift_en) begin
      count_r <= count_r + spsi_pkg::cnt_t'(1);
    end
  end

  // Capture the result of the update cycle
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      if (full) begin
        res_status_r <= spsi_pkg::ST_OVERFLOW;
        res_pos_r    <= '0;
      end else if (dup) begin
        res_status_r <= spsi_pkg::ST_DUPLICATE;
        res_pos_r    <= pos;
      end else begin
        res_status_r <= spsi_pkg::ST_INSERTED;
        res_pos_r    <= pos;
      end
    end
  end

  // Hold the result until the output side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r   <= res_status_r;
      out_position_r <= spsi_pkg::out_num_t'(res_pos_r);
      out_count_r    <= spsi_pkg::out_num_t'(count_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

endmodule

FILE: sv/spsi_chk.sv
// Port-level checker for the sorted pair set insert unit, bound to the top level.
module spsi_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input spsi_pkg::in_key_t     in_first_key,
  input spsi_pkg::in_key_t     in_second_key,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_status,
  input spsi_pkg::out_num_t    out_position,
  input spsi_pkg::out_num_t    out_count
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position) && $stable(out_count))
    else $error("stalled result changed");

  // Report only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == spsi_pkg::ST_INSERTED) ||
      (out_status == spsi_pkg::ST_DUPLICATE) || (out_status == spsi_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // Overflow reports position zero
  a_overflow_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == spsi_pkg::ST_OVERFLOW) |-> out_position == '0)
    else $error("overflow with nonzero position");

  // Inserted or found pair lies inside the stored set
  a_pos_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != spsi_pkg::ST_OVERFLOW) |-> out_position < out_count)
    else $error("position beyond entry count");

endmodule

bind sorted_pair_set_insert_unit spsi_chk u_spsi_chk (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the sorted pair set insert unit: scoreboard, drivers, monitors.
module testbench;

  // Run shape
  localparam int RANDOM_ITEMS = 1000;
  localparam int NEW_PAIR_PCT = 35;
  localparam int FORCE_FILL_AT = 820;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  // One predicted result
  typedef struct packed {
    spsi_pkg::status_t  status;
    spsi_pkg::out_num_t position;
    spsi_pkg::out_num_t count;
  } verdict_t;

  // Sorted copy of the set plus the queue of results still owed by the block
  class pair_set_scoreboard;
    spsi_pkg::pair_t stored [spsi_pkg::CAPACITY];
    int unsigned     fill;
    verdict_t        pending_verdicts [$];
    int unsigned     requests;
    int unsigned     failures;
    int unsigned     tally [3];

    function new();
      fill = 0;
      requests = 0;
      failures = 0;
      tally = '{0, 0, 0};
    endfunction

    // Apply one pair to the local set and return the result the block owes
    function verdict_t place_pair(spsi_pkg::key_t a, spsi_pkg::key_t b);
      verdict_t        v;
      spsi_pkg::pair_t p;
      int unsigned     slot;
      p = '{first: a, second: b};
      v.count = spsi_pkg::out_num_t'(fill);
      if (fill == spsi_pkg::CAPACITY) begin
        v.status   = spsi_pkg::ST_OVERFLOW;
        v.position = '0;
        return v;
      end
      // Upper bound: first stored pair strictly greater; packed order is lexicographic
      slot = 0;
      while (slot < fill && stored[slot] <= p) slot++;
      if (slot > 0 && stored[slot-1] == p) begin
        v.status   = spsi_pkg::ST_DUPLICATE;
        v.position = spsi_pkg::out_num_t'(slot - 1);
        return v;
      end
      // Shift the tail up and drop the new pair into the gap
      for (int k = fill; k > slot; k--) stored[k] = stored[k-1];
      stored[slot] = p;
      fill++;
      v.status   = spsi_pkg::ST_INSERTED;
      v.position = spsi_pkg::out_num_t'(slot);
      v.count    = spsi_pkg::out_num_t'(fill);
      return v;
    endfunction

    function void record_request(spsi_pkg::in_key_t f, spsi_pkg::in_key_t s);
      spsi_pkg::key_t a;
      spsi_pkg::key_t b;
      a = f[spsi_pkg::KEY_BITS-1:0];
      b = s[spsi_pkg::KEY_BITS-1:0];
      requests++;
      pending_verdicts.push_back(place_pair(a, b));
    endfunction

    function void check_result(logic [1:0] st, spsi_pkg::out_num_t pos,
                               spsi_pkg::out_num_t cnt);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("ERROR: unexpected result status %0d position %0d count %0d",
                   st, pos, cnt);
        return;
      end
      want = pending_verdicts.pop_front();
      tally[int'(want.status)]++;
      if (st !== want.status || pos !== want.position || cnt !== want.count) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("ERROR: result mismatch expected status %0d position %0d count %0d, %s",
                   want.status, want.position, want.count,
                   $sformatf("got %0d %0d %0d", st, pos, cnt));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  spsi_pkg::in_key_t  in_first_key = '0;
  spsi_pkg::in_key_t  in_second_key = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  spsi_pkg::out_num_t out_position;
  spsi_pkg::out_num_t out_count;

  pair_set_scoreboard sb = new();

  // Idle mix and long-hold requests shared between the two drivers
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 53;
  int unsigned hold_seq = 0;

  // Pairs offered so far that the set holds, for picking repeats
  logic [31:0]       held_pairs [$];
  bit                held_known [logic [31:0]];
  spsi_pkg::in_key_t corners [6] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE,
                                     16'hFFFF};

  sorted_pair_set_insert_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_first_key  (in_first_key),
    .in_second_key (in_second_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_position  (out_position),
    .out_count     (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.record_request(in_first_key, in_second_key);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_position, out_count);
  end

  // Result side: random stalls, plus a long hold whenever one is requested
  initial begin : receiver
    int unsigned hold_done;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_done) begin
        hold_done = hold_seq;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one pair, holding it until accepted, and track what the set now holds
  task automatic offer_pair(input spsi_pkg::in_key_t f, input spsi_pkg::in_key_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_first_key  <= f;
    in_second_key <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (!held_known.exists({f, s}) && held_pairs.size() < spsi_pkg::CAPACITY) begin
      held_known[{f, s}] = 1'b1;
      held_pairs.push_back({f, s});
    end
  endtask

  // Drop valid and wait until every outstanding result is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_verdicts.size() != 0);
    @(posedge clk);
  endtask

  // Build a pair likely to be new, biased toward crowded neighborhoods
  function automatic logic [31:0] fresh_pair();
    logic [31:0] base;
    base = held_pairs.size() ? held_pairs[$urandom_range(held_pairs.size() - 1)] : $urandom();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {corners[$urandom_range(5)], spsi_pkg::in_key_t'($urandom())};
      2: return {base[31:16], spsi_pkg::in_key_t'($urandom())};
      default: return {base[31:16], $urandom_range(1) ? base[15:0] + 16'd1 : base[15:0] - 16'd1};
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] pair;
    int unsigned idx;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: key extremes, both ends, middle, equal primaries, repeats
    offer_pair(16'h0000, 16'h0000);
    offer_pair(16'hFFFF, 16'hFFFF);
    offer_pair(16'h0000, 16'h0000);
    offer_pair(16'hFFFF, 16'hFFFF);
    offer_pair(16'h0000, 16'hFFFF);
    offer_pair(16'hFFFF, 16'h0000);
    offer_pair(16'h8000, 16'h0001);
    offer_pair(16'h8000, 16'h0000);
    offer_pair(16'h8000, 16'h0002);
    offer_pair(16'h7FFF, 16'hFFFF);
    offer_pair(16'h8001, 16'h0000);
    offer_pair(16'h8000, 16'h0001);
    offer_pair(16'h5555, 16'hAAAA);
    offer_pair(16'hAAAA, 16'h5555);
    offer_pair(16'h0000, 16'h0001);
    offer_pair(16'hFFFF, 16'hFFFE);
    offer_pair(16'h0000, 16'hFFFF);

    // Random: fill the set with a mix of new pairs and repeats, then hammer it when full
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx == RANDOM_ITEMS / 3) begin
        wait_for_drain();
        send_idle_pct = 53;
        recv_idle_pct <= 27;
      end
      if (idx == 2 * RANDOM_ITEMS / 3) begin
        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (idx == 100 || idx == 750) hold_seq <= hold_seq + 1;
      if (idx == 500) wait_for_drain();
      if (held_pairs.size() == spsi_pkg::CAPACITY)
        pair = $urandom_range(1) ? held_pairs[$urandom_range(spsi_pkg::CAPACITY - 1)]
                                 : fresh_pair();
      else if (idx >= FORCE_FILL_AT || $urandom_range(99) < NEW_PAIR_PCT)
        pair = fresh_pair();
      else
        pair = held_pairs[$urandom_range(held_pairs.size() - 1)];
      offer_pair(pair[31:16], pair[15:0]);
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d inserted, %0d duplicate, %0d overflow.",
             sb.requests, sb.tally[0], sb.tally[1], sb.tally[2]);
    $display("Set reached %0d of %0d pairs under three stall mixes and two long output holds.",
             sb.fill, spsi_pkg::CAPACITY);
    if (sb.failures == 0 && sb.pending_verdicts.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
